>>> rtl/core/ppr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Park / inverse Park rotator package
// Shared widths, item types, CORDIC arctangent table and the gain constant.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int ROTATION_STAGES = 16;

  localparam int ATAN_LEN      = 32;
  localparam int CORDIC_STAGES = (ROTATION_STAGES > ATAN_LEN) ? ATAN_LEN : ROTATION_STAGES;

  // Angle is carried as a 32-bit fraction of one turn.
  localparam int TURN_WIDTH = 32;

  // Vector datapath: sign head, data bits, guard fraction bits.
  localparam int GUARD_BITS = 60 - DATA_WIDTH;
  localparam int VEC_WIDTH  = 64;
  localparam int HEAD_BITS  = VEC_WIDTH - DATA_WIDTH - GUARD_BITS;

  // 1/K of the CORDIC, as a 32-bit fraction.
  localparam int          GAIN_WIDTH = 32;
  localparam logic [GAIN_WIDTH-1:0] GAIN_Q32 = 32'd2608131496;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic signed [TURN_WIDTH-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1,         32'sd1,         32'sd0
  };

  // Operation select: forward Park rotates by minus the angle.
  localparam logic OP_FORWARD = 1'b0;

  typedef struct packed {
    logic                         operation;
    logic signed [DATA_WIDTH-1:0] first_component;
    logic signed [DATA_WIDTH-1:0] second_component;
    logic        [ANGLE_WIDTH-1:0] rotor_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] first_result;
    logic signed [DATA_WIDTH-1:0] second_result;
  } out_item_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  x;
    logic signed [VEC_WIDTH-1:0]  y;
    logic signed [TURN_WIDTH-1:0] z;
  } vec_t;

endpackage
`default_nettype wire

>>> rtl/core/ppr_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotator input stage
// Widens the angle, picks the nearest quarter turn, pre-rotates the vector
// exactly and leaves the residual angle for the CORDIC. One register stage.
// ----------------------------------------------------------------------------
module ppr_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  ppr_pkg::in_item_t s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output ppr_pkg::vec_t    m_data
);
  import ppr_pkg::*;

  localparam logic [1:0] QUAD_ZERO  = 2'd0;
  localparam logic [1:0] QUAD_ONE   = 2'd1;
  localparam logic [1:0] QUAD_TWO   = 2'd2;
  localparam logic [1:0] QUAD_THREE = 2'd3;

  localparam logic [TURN_WIDTH-1:0] EIGHTH_TURN = TURN_WIDTH'(1) << (TURN_WIDTH - 3);

  logic [TURN_WIDTH-1:0]       ang;
  logic [TURN_WIDTH-1:0]       ang_sum;
  logic [1:0]                  quad;
  logic signed [VEC_WIDTH-1:0] a;
  logic signed [VEC_WIDTH-1:0] b;
  vec_t                        vec_nxt;
  vec_t                        vec_r;
  logic                        valid_r;

  always_comb begin
    ang = TURN_WIDTH'(s_data.rotor_angle) << (TURN_WIDTH - ANGLE_WIDTH);
    if (s_data.operation == OP_FORWARD) begin
      ang = '0 - ang;
    end
    ang_sum = ang + EIGHTH_TURN;
    quad    = ang_sum[TURN_WIDTH-1 -: 2];
    a = {{HEAD_BITS{s_data.first_component[DATA_WIDTH-1]}}, s_data.first_component,
         {GUARD_BITS{1'b0}}};
    b = {{HEAD_BITS{s_data.second_component[DATA_WIDTH-1]}}, s_data.second_component,
         {GUARD_BITS{1'b0}}};
    // residual lands in [-1/8, 1/8) turn
    vec_nxt.z = $signed({2'b00, ang_sum[TURN_WIDTH-3:0]}) - $signed(EIGHTH_TURN);
    unique case (quad)
      QUAD_ZERO: begin
        vec_nxt.x = a;
        vec_nxt.y = b;
      end
      QUAD_ONE: begin
        vec_nxt.x = -b;
        vec_nxt.y = a;
      end
      QUAD_TWO: begin
        vec_nxt.x = -a;
        vec_nxt.y = -b;
      end
      QUAD_THREE: begin
        vec_nxt.x = b;
        vec_nxt.y = -a;
      end
    endcase
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      vec_r <= vec_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = vec_r;

endmodule
`default_nettype wire

>>> rtl/core/ppr_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotator CORDIC pipeline
// One micro-rotation per register stage, steered by the sign of the residual
// angle. Each stage holds its item until the next stage can take it.
// ----------------------------------------------------------------------------
module ppr_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  output logic          s_ready,
  input  ppr_pkg::vec_t s_data,
  output logic          m_valid,
  input  logic          m_ready,
  output ppr_pkg::vec_t m_data
);
  import ppr_pkg::*;

  logic valid_r [CORDIC_STAGES];
  vec_t vec_r   [CORDIC_STAGES];
  logic stg_rdy [CORDIC_STAGES+1];

  assign stg_rdy[CORDIC_STAGES] = m_ready;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic                        stg_vld;
    vec_t                        stg_in;
    vec_t                        vec_nxt;
    logic signed [VEC_WIDTH-1:0] dx;
    logic signed [VEC_WIDTH-1:0] dy;

    if (k == 0) begin : g_head
      assign stg_vld = s_valid;
      assign stg_in  = s_data;
    end else begin : g_body
      assign stg_vld = valid_r[k-1];
      assign stg_in  = vec_r[k-1];
    end

    assign stg_rdy[k] = !valid_r[k] || stg_rdy[k+1];

    always_comb begin
      dx = stg_in.y >>> k;
      dy = stg_in.x >>> k;
      // zero residual counts as positive
      if (!stg_in.z[TURN_WIDTH-1]) begin
        vec_nxt.x = stg_in.x - dx;
        vec_nxt.y = stg_in.y + dy;
        vec_nxt.z = stg_in.z - ATAN_TURNS[k];
      end else begin
        vec_nxt.x = stg_in.x + dx;
        vec_nxt.y = stg_in.y - dy;
        vec_nxt.z = stg_in.z + ATAN_TURNS[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (stg_rdy[k]) begin
        valid_r[k] <= stg_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[k] && stg_vld) begin
        vec_r[k] <= vec_nxt;
      end
    end
  end

  assign s_ready = stg_rdy[0];
  assign m_valid = valid_r[CORDIC_STAGES-1];
  assign m_data  = vec_r[CORDIC_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/core/ppr_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotator gain correction
// Three stages per component: magnitude, split 32-bit gain products, then
// sum with rounding (halves away from zero), sign restore and saturation.
// ----------------------------------------------------------------------------
module ppr_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  ppr_pkg::vec_t      s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output ppr_pkg::out_item_t m_data
);
  import ppr_pkg::*;

  localparam int MAG_WIDTH = VEC_WIDTH - 1;
  localparam int SPLIT     = GAIN_WIDTH;
  localparam int HI_WIDTH  = MAG_WIDTH - SPLIT;
  localparam int LO_PROD_W = 2 * SPLIT;
  localparam int HI_PROD_W = HI_WIDTH + SPLIT;
  localparam int SUM_W     = HI_PROD_W + 1;

  localparam logic [SUM_W-1:0]      ROUND    = SUM_W'(1) << (GUARD_BITS - 1);
  localparam logic [SUM_W-1:0]      LIM      = SUM_W'(1) << (DATA_WIDTH - 1);
  localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [VEC_WIDTH-1:0] lane_v   [2];
  logic                        neg_nxt  [2];
  logic [MAG_WIDTH-1:0]        mag_nxt  [2];
  logic                        neg1_r   [2];
  logic [MAG_WIDTH-1:0]        mag_r    [2];
  logic [LO_PROD_W-1:0]        plo_nxt  [2];
  logic [HI_PROD_W-1:0]        phi_nxt  [2];
  logic                        neg2_r   [2];
  logic [LO_PROD_W-1:0]        plo_r    [2];
  logic [HI_PROD_W-1:0]        phi_r    [2];
  logic [SUM_W-1:0]            sum      [2];
  logic [SUM_W-1:0]            mag3     [2];
  logic [DATA_WIDTH-1:0]       res_nxt  [2];
  out_item_t                   out_r;
  logic                        v1_r;
  logic                        v2_r;
  logic                        v3_r;
  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy3;

  assign rdy3    = !v3_r || m_ready;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign s_ready = rdy1;

  assign lane_v[0] = s_data.x;
  assign lane_v[1] = s_data.y;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      neg_nxt[l] = lane_v[l][VEC_WIDTH-1];
      mag_nxt[l] = neg_nxt[l] ? MAG_WIDTH'(-lane_v[l]) : MAG_WIDTH'(lane_v[l]);
      plo_nxt[l] = mag_r[l][SPLIT-1:0] * GAIN_Q32;
      phi_nxt[l] = mag_r[l][MAG_WIDTH-1:SPLIT] * GAIN_Q32;
      sum[l]     = SUM_W'(phi_r[l]) + SUM_W'(plo_r[l][LO_PROD_W-1:SPLIT]) + ROUND;
      mag3[l]    = sum[l] >> GUARD_BITS;
      if (neg2_r[l]) begin
        res_nxt[l] = (mag3[l] >= LIM) ? DATA_MIN : DATA_WIDTH'(SUM_W'(0) - mag3[l]);
      end else begin
        res_nxt[l] = (mag3[l] >= LIM) ? DATA_MAX : DATA_WIDTH'(mag3[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= s_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_valid) begin
      neg1_r <= neg_nxt;
      mag_r  <= mag_nxt;
    end
    if (rdy2 && v1_r) begin
      neg2_r <= neg1_r;
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
    end
    if (rdy3 && v2_r) begin
      out_r.first_result  <= res_nxt[0];
      out_r.second_result <= res_nxt[1];
    end
  end

  assign m_valid = v3_r;
  assign m_data  = out_r;

endmodule
`default_nettype wire

>>> rtl/core/park_inverse_park_rotator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Park / inverse Park vector rotator
// Rotates a signed Q1.15 vector by the rotor angle for field-oriented control.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries operation (0 forward Park,
// alpha-beta to d-q; 1 inverse Park, d-q to alpha-beta), the two components
// and the rotor angle as a fraction of a turn. Output channel
// out_valid/out_ready/out_data returns one saturated result per item, in
// order.
// The pipeline has one quarter-turn pre-rotation stage, one stage per CORDIC
// micro-rotation and three stages of gain multiply, rounding and saturation.
// Throughput is one item per clock while the receiver does not stall.
// Every stage has its own valid bit and holds its item while the one after
// it is full, so when the receiver stalls, bubbles close up first and
// in_ready drops only once the whole pipeline is full.
// Synchronous reset (rst_n low) empties the pipeline; no item is lost or
// repeated across a stall. The block keeps no state between items.
// ----------------------------------------------------------------------------
module park_inverse_park_rotator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppr_pkg::out_item_t out_data
);
  import ppr_pkg::*;

  vec_t prep_vec;
  vec_t rot_vec;
  logic prep_valid;
  logic prep_ready;
  logic rot_valid;
  logic rot_ready;

  ppr_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_data  (in_data),
    .m_valid (prep_valid),
    .m_ready (prep_ready),
    .m_data  (prep_vec)
  );

  ppr_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (prep_valid),
    .s_ready (prep_ready),
    .s_data  (prep_vec),
    .m_valid (rot_valid),
    .m_ready (rot_ready),
    .m_data  (rot_vec)
  );

  ppr_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (rot_valid),
    .s_ready (rot_ready),
    .s_data  (rot_vec),
    .m_valid (out_valid),
    .m_ready (out_ready),
    .m_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/core/ppr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotator port checker
// Watches the top-level ports for reset, flow control and stall behavior.
// ----------------------------------------------------------------------------
module ppr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ppr_pkg::out_item_t out_data
);

  // reset empties the pipeline on the next edge
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a free output end means every stage can move, so input is open
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while output side is free");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

endmodule

bind park_inverse_park_rotator_unit ppr_checker u_ppr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

>>> tb/sv/park_inverse_park_rotator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Park / inverse Park rotator testbench
// Streams forward and inverse Park items through the rotator with bursty input
// and a stalling receiver, predicts each result with a bit-true CORDIC model
// and checks every result in order against it.
// ----------------------------------------------------------------------------
module park_inverse_park_rotator_unit_test;

  localparam int DW          = ppr_pkg::DATA_WIDTH;
  localparam int AW          = ppr_pkg::ANGLE_WIDTH;
  localparam int GUARD       = 60 - DW;
  localparam int N_STAGES    = (ppr_pkg::ROTATION_STAGES > 32) ? 32 : ppr_pkg::ROTATION_STAGES;
  localparam int N_RANDOM    = 1650;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_LIMIT  = 10;

  localparam logic OP_INVERSE = ~ppr_pkg::OP_FORWARD;

  // 1/K of the CORDIC as a 32-bit fraction
  localparam logic [63:0] INV_GAIN = 64'd2608131496;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic signed [31:0] ARC_TURNS [32] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1,         32'sd1,         32'sd0
  };

  localparam logic signed [15:0] EDGE_VALS [6] = '{
    -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd32767
  };

  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_HOLD, RX_MOSTLY} rx_mode_e;

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  ppr_pkg::in_item_t  in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ppr_pkg::out_item_t out_data;

  ppr_pkg::in_item_t  rotation_q [$];
  ppr_pkg::out_item_t expected_q [$];

  int n_total     = 0;
  int n_accepted  = 0;
  int n_forward   = 0;
  int n_inverse   = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int rx_left     = 0;
  rx_mode_e rx_mode = RX_FLOW;
  ppr_pkg::out_item_t want;

  park_inverse_park_rotator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Remove the CORDIC gain, round halves away from zero, drop guard bits, clip.
  function automatic logic signed [DW-1:0] descale(logic signed [63:0] v);
    logic        neg;
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mag;
    longint      r;
    neg = v[63];
    m   = neg ? -v : v;
    lo  = {32'd0, m[31:0]} * INV_GAIN;
    hi  = (m >> 32) * INV_GAIN;
    hi  = hi + (64'd1 << (GUARD - 1));
    mag = (hi + (lo >> 32)) >> GUARD;
    if (mag > (64'd1 << DW)) mag = 64'd1 << DW;
    r = neg ? -longint'(mag) : longint'(mag);
    if (r > (longint'(1) << (DW - 1)) - 1) r = (longint'(1) << (DW - 1)) - 1;
    if (r < -(longint'(1) << (DW - 1))) r = -(longint'(1) << (DW - 1));
    return r[DW-1:0];
  endfunction

  function automatic ppr_pkg::out_item_t park_rotate(ppr_pkg::in_item_t it);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] t;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic [31:0]        turn;
    logic [31:0]        biased;
    logic signed [31:0] resid;
    ppr_pkg::out_item_t res;
    x = $signed(it.first_component);
    y = $signed(it.second_component);
    x = x <<< GUARD;
    y = y <<< GUARD;
    turn = 32'(it.rotor_angle) << (32 - AW);
    // forward Park rotates by minus the angle
    if (it.operation == ppr_pkg::OP_FORWARD) turn = -turn;
    // nearest quarter turn, ties upward; residual within +-1/8 turn
    biased = turn + 32'h2000_0000;
    resid  = $signed({2'b00, biased[29:0]}) - 32'sd536870912;
    case (biased[31:30])
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < N_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (resid >= 0) begin
        x = x - dx; y = y + dy; resid = resid - ARC_TURNS[i];
      end else begin
        x = x + dx; y = y - dy; resid = resid + ARC_TURNS[i];
      end
    end
    res.first_result  = descale(x);
    res.second_result = descale(y);
    return res;
  endfunction

  task automatic add_rotation(logic op, logic signed [15:0] a, logic signed [15:0] b,
                              logic [15:0] ang);
    ppr_pkg::in_item_t it;
    it.operation        = op;
    it.first_component  = a;
    it.second_component = b;
    it.rotor_angle      = ang;
    rotation_q.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items accepted, %0d results checked",
               cycle_count, n_accepted, n_checked);
      $display("Some tests failed");
      $finish;
    end
  end

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(park_rotate(in_data));
        n_accepted <= n_accepted + 1;
        if (in_data.operation == ppr_pkg::OP_FORWARD) n_forward <= n_forward + 1;
        else n_inverse <= n_inverse + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (rotation_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= rotation_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1:    gap_left <= 0;
              7:       gap_left <= $urandom_range(10, 30);
              default: gap_left <= $urandom_range(1, 5);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switch between flowing, coin-flip, held and mostly-ready phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left   <= 0;
      rx_mode   <= RX_FLOW;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(1, 40);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FLOW:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_HOLD:   out_ready <= 1'b0;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_LIMIT)
          $display("Unexpected result (%0d, %0d) with nothing pending",
                   out_data.first_result, out_data.second_result);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (out_data.first_result !== want.first_result ||
            out_data.second_result !== want.second_result) begin
          n_errors++;
          if (n_errors <= SHOW_LIMIT)
            $display("Result %0d mismatch: first expected %0d got %0d, second expected %0d got %0d",
                     n_checked, want.first_result, out_data.first_result,
                     want.second_result, out_data.second_result);
        end
      end
    end
  end

  initial begin
    int                kind;
    int                ang_i;
    logic              op;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [15:0]       ang;

    // full-scale corners, exact quarter turns, quarter-turn ties and
    // vectors longer than full scale
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh7FFF, 16'sh8000, 16'h0000);
    add_rotation(OP_INVERSE,          16'sh8000, 16'sh7FFF, 16'h0000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh7FFF, 16'sh0000, 16'h4000);
    add_rotation(OP_INVERSE,          16'sh7FFF, 16'sh0000, 16'h4000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh0000, 16'sh7FFF, 16'h8000);
    add_rotation(OP_INVERSE,          16'sh8000, 16'sh8000, 16'hC000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh7FFF, 16'sh7FFF, 16'h2000);
    add_rotation(OP_INVERSE,          16'sh7FFF, 16'sh7FFF, 16'h2000);
    add_rotation(OP_INVERSE,          16'sh8000, 16'sh8000, 16'h6000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh8000, 16'sh7FFF, 16'hE000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh0000, 16'sh0000, 16'hFFFF);
    add_rotation(OP_INVERSE,          16'sh3039, -16'sh1F40, 16'hFFFF);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh8000, 16'sh8000, 16'h8000);
    add_rotation(OP_INVERSE,          16'sh8000, 16'sh0000, 16'h0000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh0001, -16'sh0001, 16'h1FFF);
    add_rotation(OP_INVERSE,          -16'sh0001, 16'sh0001, 16'hA000);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh4000, -16'sh4000, 16'h1000);
    add_rotation(OP_INVERSE,          16'sh7FFF, 16'sh8000, 16'h9FFF);
    add_rotation(ppr_pkg::OP_FORWARD, 16'sh5A82, 16'sh5A82, 16'hA000);
    add_rotation(OP_INVERSE,          16'sh7FFF, 16'sh7FFF, 16'h5555);

    for (int n = 0; n < N_RANDOM; n++) begin
      op    = 1'($urandom_range(0, 1));
      a     = 16'($urandom_range(0, 65535));
      b     = 16'($urandom_range(0, 65535));
      ang   = 16'($urandom_range(0, 65535));
      kind  = $urandom_range(0, 9);
      case (kind)
        6: begin
          a = EDGE_VALS[$urandom_range(0, 5)];
          b = EDGE_VALS[$urandom_range(0, 5)];
        end
        7: begin
          // straddle the quarter-turn rounding boundaries
          ang_i = 'h2000 + 'h4000 * int'($urandom_range(0, 3)) + int'($urandom_range(0, 4)) - 2;
          ang   = ang_i[15:0];
        end
        8: begin
          a = $urandom_range(0, 1) ? 16'($urandom_range(28000, 32767))
                                   : -16'($urandom_range(28000, 32768));
          b = $urandom_range(0, 1) ? 16'($urandom_range(28000, 32767))
                                   : -16'($urandom_range(28000, 32768));
        end
        9: begin
          a = 16'(int'($urandom_range(0, 8)) - 4);
          b = 16'(int'($urandom_range(0, 8)) - 4);
        end
        default: ;
      endcase
      add_rotation(op, a, b, ang);
    end
    n_total = rotation_q.size();

    while (n_accepted < n_total || expected_q.size() != 0) @(posedge clk);
    // hold a while longer to catch any stray result
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d rotations (%0d forward Park, %0d inverse Park) in %0d cycles,",
             n_checked, n_forward, n_inverse, cycle_count);
    $display("with bursty input, receiver stalls, quarter-turn ties and saturating vectors");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, expected_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
